// ===== rtl/interrupt_controller_with_hram_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Interrupt controller assertion macros
// Clocked assertion helpers shared by the interrupt controller RTL.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_CONTROLLER_WITH_HRAM_UNIT_ASSERT_SVH
`define INTERRUPT_CONTROLLER_WITH_HRAM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ICH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ICH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ICH_ASSERT(label, prop, msg)
`define ICH_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/ich_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt controller package
// Transaction types, bus map constants and request kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ich_pkg;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_IRQ   = 2'd2;
  localparam logic [1:0] REQ_CHECK = 2'd3;

  localparam logic [15:0] ADDR_IF    = 16'hFF0F;
  localparam logic [15:0] ADDR_IE    = 16'hFFFF;
  localparam logic [15:0] HRAM_FIRST = 16'hFF80;
  localparam logic [15:0] HRAM_LAST  = 16'hFFFE;
  localparam logic [7:0]  OPEN_BUS   = 8'hFF;
  localparam logic [6:0]  VECTOR_BASE = 7'h40;

  localparam int HRAM_DEPTH  = 127;
  localparam int HRAM_WIDTH  = 8;
  localparam int HRAM_AW     = $clog2(HRAM_DEPTH);
  localparam int NUM_SOURCES = 5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  int_source;
    logic        master_enable;
    logic        cpu_halted;
    logic        cpu_stopped;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dispatch;
    logic [6:0] vector_address;
    logic       wake;
    logic       idle_tick;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ich_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ich_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/interrupt_controller_with_hram_unit.sv =====
// ----------------------------------------------------------------------------
// Interrupt controller with high RAM
// Flag and enable registers, fixed priority dispatch and a small high RAM.
// ----------------------------------------------------------------------------
//  channel   signals                              role
//  item      item_valid, item_stall, item         bus access, request or check
//  result    result_valid, result_stall, result   one result per transaction
//
//  One transaction is accepted per cycle unless the input stalls; its result
//  passes from the stage and RAM read registers into the result register.
//  Reset is synchronous; high RAM entries carry valid bits that reset clears
//  at once, so no clearing pass is needed.
//  A stalled result is held in the result register while one more transaction
//  waits in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_controller_with_hram_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire ich_pkg::item_t  item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output ich_pkg::result_t     result
);

  import ich_pkg::*;

`include "interrupt_controller_with_hram_unit_assert.svh"

  typedef struct packed {
    result_t res;
    logic    ram_sel;
    logic    ram_hit;
  } stage_t;

  logic [7:0]            request_flags;
  logic [7:0]            request_flags_next;
  logic [7:0]            enable_mask;
  logic [7:0]            enable_mask_next;
  logic [HRAM_DEPTH-1:0] ram_valid;
  logic [HRAM_DEPTH-1:0] ram_valid_next;

  stage_t                s1;
  stage_t                s1_next;
  result_t               s1_res;
  logic                  s1_valid;
  logic                  s1_move;
  logic                  accept;

  logic                  in_hram;
  logic [HRAM_AW-1:0]    ram_idx;
  logic                  ram_we;
  logic                  ram_re;
  logic [HRAM_WIDTH-1:0] ram_rdata;

  logic [NUM_SOURCES-1:0] ready;
  logic [2:0]             first_src;
  logic                   take;

  assign s1_move    = !result_valid || !result_stall;
  assign item_stall = rst || (s1_valid && !s1_move);
  assign accept     = item_valid && !item_stall;

  assign in_hram = (item.address >= HRAM_FIRST) && (item.address <= HRAM_LAST);
  assign ram_idx = item.address[HRAM_AW-1:0];
  assign ram_we  = accept && (item.req_type == REQ_WRITE) && in_hram;
  assign ram_re  = accept && (item.req_type == REQ_READ) && in_hram;

  assign ready = request_flags[NUM_SOURCES-1:0] & enable_mask[NUM_SOURCES-1:0];
  assign take  = (ready != '0) && item.master_enable;

  always_comb begin
    first_src = 3'(NUM_SOURCES - 1);
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (ready[i]) begin
        first_src = 3'(i);
      end
    end
  end

  always_comb begin
    request_flags_next = request_flags;
    enable_mask_next   = enable_mask;
    ram_valid_next     = ram_valid;
    s1_next            = '0;
    unique case (item.req_type)
      REQ_READ: begin
        if (item.address == ADDR_IF) begin
          s1_next.res.read_data = request_flags;
        end else if (item.address == ADDR_IE) begin
          s1_next.res.read_data = enable_mask;
        end else if (in_hram) begin
          s1_next.ram_sel = 1'b1;
          s1_next.ram_hit = ram_valid[ram_idx];
        end else begin
          s1_next.res.read_data = OPEN_BUS;
        end
      end
      REQ_WRITE: begin
        if (item.address == ADDR_IF) begin
          request_flags_next = item.write_data;
        end else if (item.address == ADDR_IE) begin
          enable_mask_next = item.write_data;
        end else if (in_hram) begin
          ram_valid_next[ram_idx] = 1'b1;
        end
      end
      REQ_IRQ: begin
        request_flags_next = request_flags | (8'b1 << item.int_source);
      end
      REQ_CHECK: begin
        s1_next.res.wake = (ready != '0);
        if (take) begin
          request_flags_next = request_flags & ~(8'b1 << first_src);
          s1_next.res.dispatch = 1'b1;
          s1_next.res.vector_address = VECTOR_BASE + 7'({first_src, 3'b000});
        end
        s1_next.res.idle_tick = !take &&
          ((item.cpu_halted && (ready == '0)) || item.cpu_stopped);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_res = s1.res;
    if (s1.ram_sel) begin
      s1_res.read_data = s1.ram_hit ? ram_rdata : 8'h00;
    end
  end

  ich_ram #(
    .WIDTH(HRAM_WIDTH),
    .DEPTH(HRAM_DEPTH)
  ) u_hram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_idx),
    .wdata(item.write_data),
    .re   (ram_re),
    .raddr(ram_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      request_flags <= '0;
      enable_mask   <= '0;
      ram_valid     <= '0;
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        request_flags <= request_flags_next;
        enable_mask   <= enable_mask_next;
        ram_valid     <= ram_valid_next;
        s1_valid      <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_move && s1_valid) begin
      result <= s1_res;
    end
  end

  `ICH_ASSERT(a_dispatch_clears_one, accept && (item.req_type == REQ_CHECK) && take |=> ($countones(request_flags) == $countones($past(request_flags)) - 1), "dispatch must clear exactly one flag")
  `ICH_ASSERT(a_stall_needs_stage, item_stall |-> s1_valid, "input stalled with an empty stage")
  `ICH_ASSERT(a_stage_kept, s1_valid && !s1_move |=> s1_valid, "waiting transaction lost")
  `ICH_ASSERT(a_dispatch_wakes, result_valid && result.dispatch |-> result.wake && !result.idle_tick, "dispatch without wake or with idle")
  `ICH_ASSERT_ALWAYS(a_reset_stalls, rst |-> item_stall, "input must stall during reset")

endmodule

`default_nettype wire

// ===== tb/interrupt_controller_with_hram_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interrupt controller with high RAM testbench
// Drives bus reads, bus writes, interrupt requests and cycle checks into the
// block. A scoreboard tracks the flag, enable and high RAM state and predicts
// each result. Both channels idle and stall at random. Every result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_controller_with_hram_unit_tb;
  import ich_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int BLOCK_ITEMS  = 150;
  localparam int SETTLE_WAIT  = 8;

  class irq_hram_scoreboard;
    logic [7:0] irq_flags;
    logic [7:0] irq_enables;
    logic [7:0] hram [HRAM_DEPTH];
    result_t    expected_results [$];
    int unsigned fail_count;

    function new();
      irq_flags   = '0;
      irq_enables = '0;
      foreach (hram[i]) hram[i] = '0;
      fail_count  = 0;
    endfunction

    function void note_item(item_t it);
      result_t    r;
      logic [4:0] ready;
      int         n;
      r = '0;
      n = 0;
      case (it.req_type)
        REQ_READ: begin
          if (it.address == ADDR_IF) r.read_data = irq_flags;
          else if (it.address == ADDR_IE) r.read_data = irq_enables;
          else if (it.address >= HRAM_FIRST && it.address <= HRAM_LAST)
            r.read_data = hram[it.address[6:0]];
          else r.read_data = OPEN_BUS;
        end
        REQ_WRITE: begin
          if (it.address == ADDR_IF) irq_flags = it.write_data;
          else if (it.address == ADDR_IE) irq_enables = it.write_data;
          else if (it.address >= HRAM_FIRST && it.address <= HRAM_LAST)
            hram[it.address[6:0]] = it.write_data;
        end
        REQ_IRQ: begin
          irq_flags[it.int_source] = 1'b1;
        end
        default: begin
          ready = irq_flags[4:0] & irq_enables[4:0];
          if (ready != '0) begin
            r.wake = 1'b1;
            if (it.master_enable) begin
              for (int i = NUM_SOURCES - 1; i >= 0; i--) if (ready[i]) n = i;
              irq_flags[n] = 1'b0;
              r.dispatch = 1'b1;
              r.vector_address = VECTOR_BASE + 7'(8 * n);
            end
          end
          r.idle_tick = !r.dispatch && ((it.cpu_halted && !r.wake) || it.cpu_stopped);
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h with nothing pending", $time, got);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                 got.read_data);
        fail_count++;
      end
      if (got.dispatch !== want.dispatch) begin
        $display("%0t: dispatch expected %b actual %b", $time, want.dispatch,
                 got.dispatch);
        fail_count++;
      end
      if (got.vector_address !== want.vector_address) begin
        $display("%0t: vector_address expected %h actual %h", $time,
                 want.vector_address, got.vector_address);
        fail_count++;
      end
      if (got.wake !== want.wake) begin
        $display("%0t: wake expected %b actual %b", $time, want.wake, got.wake);
        fail_count++;
      end
      if (got.idle_tick !== want.idle_tick) begin
        $display("%0t: idle_tick expected %b actual %b", $time, want.idle_tick,
                 got.idle_tick);
        fail_count++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  irq_hram_scoreboard scoreboard;
  logic               tx_idle_on;
  logic               rx_idle_on;
  int unsigned        cycle_count;

  interrupt_controller_with_hram_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t make_item(logic [1:0] kind, logic [15:0] addr,
                                      logic [7:0] wdata, logic [2:0] src,
                                      logic ime, logic halted, logic stopped);
    item_t it;
    it.req_type      = kind;
    it.address       = addr;
    it.write_data    = wdata;
    it.int_source    = src;
    it.master_enable = ime;
    it.cpu_halted    = halted;
    it.cpu_stopped   = stopped;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it = make_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                   3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    if (it.req_type == REQ_READ || it.req_type == REQ_WRITE) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) it.address = HRAM_FIRST + 16'($urandom_range(0, HRAM_DEPTH - 1));
      else if (pick < 50) it.address = ADDR_IF;
      else if (pick < 65) it.address = ADDR_IE;
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    scoreboard.note_item(it);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) scoreboard.check_result(result);
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (rx_idle_on) stall_left = pick_gap();
      end
    end
  end

  initial begin : item_side
    int mode;
    scoreboard   = new();
    cycle_count  = 0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(make_item(REQ_READ,  ADDR_IF,     8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  ADDR_IE,     8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  HRAM_LAST,   8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_WRITE, HRAM_FIRST,  8'hA5, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_WRITE, HRAM_LAST,   8'h5A, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_WRITE, 16'h0000,    8'hFF, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_WRITE, 16'hFF7F,    8'h11, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  16'h0000,    8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  16'hFF7F,    8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  HRAM_FIRST,  8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  HRAM_LAST,   8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_CHECK, 16'h0000,    8'h00, 3'd0, 1'b1, 1'b1, 1'b0));
    for (int s = 7; s >= 0; s--)
      send_item(make_item(REQ_IRQ, 16'h0000, 8'h00, 3'(s), 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  ADDR_IF,     8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_CHECK, 16'h0000,    8'h00, 3'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(REQ_WRITE, ADDR_IE,     8'hFF, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_CHECK, 16'h0000,    8'h00, 3'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(REQ_CHECK, 16'hFFFF,    8'hFF, 3'd7, 1'b1, 1'b0, 1'b1));
    for (int k = 0; k < 4; k++)
      send_item(make_item(REQ_CHECK, 16'h0000, 8'h00, 3'd0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(REQ_CHECK, 16'h0000,    8'h00, 3'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(REQ_WRITE, ADDR_IF,     8'h00, 3'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(REQ_READ,  ADDR_IE,     8'h00, 3'd0, 1'b0, 1'b0, 1'b0));

    for (int blk = 0; blk * BLOCK_ITEMS < RANDOM_ITEMS; blk++) begin
      mode = (blk == 2) ? 0 : $urandom_range(0, 3);
      tx_idle_on = (blk == 0) || mode[0];
      rx_idle_on = (blk == 0) || mode[1];
      if (blk == 5) drain_results();
      for (int k = 0; k < BLOCK_ITEMS; k++) send_item(random_item());
    end

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (scoreboard.fail_count == 0 && scoreboard.expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
